/* hdl/rosd_pkg.sv */
// shared types and constants for the rebase opcode stream decoder
`default_nettype none
package rosd_pkg;
	localparam int POSITION_BITS = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam logic [63:0] SLOT_STEP = 64'd8;

	localparam logic [3:0] OP_DONE = 4'h0;
	localparam logic [3:0] OP_SET_TYPE = 4'h1;
	localparam logic [3:0] OP_SET_SEG = 4'h2;
	localparam logic [3:0] OP_ADD_ULEB = 4'h3;
	localparam logic [3:0] OP_ADD_IMM = 4'h4;
	localparam logic [3:0] OP_REB_IMM = 4'h5;
	localparam logic [3:0] OP_REB_ULEB = 4'h6;
	localparam logic [3:0] OP_REB_SKIP = 4'h7;
	localparam logic [3:0] OP_REB_ULEB_SKIP = 4'h8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_UNKNOWN_OP = 3'd1;
	localparam logic [2:0] ST_BAD_SEG = 3'd2;
	localparam logic [2:0] ST_NO_SEG = 3'd3;
	localparam logic [2:0] ST_BAD_TYPE = 3'd4;
	localparam logic [2:0] ST_SLOT_LIMIT = 3'd5;
	localparam logic [2:0] ST_BAD_ULEB = 3'd6;

	localparam logic [0:0] KIND_RUN = 1'b0;
	localparam logic [0:0] KIND_FINISH = 1'b1;

	localparam logic [0:0] CFG_SEGMENT_COUNT = 1'b0;
	localparam logic [0:0] CFG_SLOT_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		PH_OPCODE,
		PH_ULEB1,
		PH_ULEB2
	} phase_t;

	// one command from the front to the back
	typedef struct packed {
		logic        is_run;      // emit a run record
		logic        is_fin;      // emit a finish record
		logic        fin_after;   // finish follows the run on the same beat
		logic [3:0]  segment;
		logic [3:0]  rtype;
		logic [63:0] start;
		logic [31:0] count;
		logic [63:0] stride;
		logic [2:0]  status;
		logic [31:0] end_pos;
	} cmd_t;

	typedef struct packed {
		logic [0:0]  record_kind;
		logic [3:0]  segment;
		logic [3:0]  rebase_type;
		logic [63:0] start_offset;
		logic [31:0] run_count;
		logic [63:0] stride;
		logic [2:0]  status;
		logic [31:0] end_position;
	} rec_t;
endpackage
`default_nettype wire

/* hdl/rosd_if.sv */
// valid/ready channel interfaces for bytes, records and configuration
`default_nettype none
interface rosd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       last_byte;
	modport source (output valid, output stream_byte, output last_byte, input ready);
	modport sink (input valid, input stream_byte, input last_byte, output ready);
endinterface

interface rosd_rec_if;
	logic        valid;
	logic        ready;
	logic [0:0]  record_kind;
	logic [3:0]  segment;
	logic [3:0]  rebase_type;
	logic [63:0] start_offset;
	logic [31:0] run_count;
	logic [63:0] stride;
	logic [2:0]  status;
	logic [31:0] end_position;
	modport source (output valid, output record_kind, output segment, output rebase_type,
		output start_offset, output run_count, output stride, output status,
		output end_position, input ready);
	modport sink (input valid, input record_kind, input segment, input rebase_type,
		input start_offset, input run_count, input stride, input status,
		input end_position, output ready);
endinterface

interface rosd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/rosd_front.sv */
// front end: opcode and uleb parsing, checks, offset tracking, command issue
`default_nettype none
module rosd_front
	import rosd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] stream_byte,
	input  wire logic       last_byte,
	input  wire logic [4:0] segment_count,
	input  wire logic [31:0] slot_limit,
	output logic            cmd_push,
	output cmd_t            cmd,
	input  wire logic       cmd_full
);
	phase_t                   phase_q;
	logic [3:0]               op_q;
	logic [63:0]              acc_q;
	logic [6:0]               shift_q;
	logic [63:0]              first_q;
	logic [3:0]               seg_q;
	logic                     seg_valid_q;
	logic [3:0]               type_q;
	logic [63:0]              offset_q;
	logic [31:0]              used_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] op_pos_q;
	logic                     fin_q;
	// pending offset advance count*stride, folded in on the next accepted byte
	logic                     adv_pend_q;
	logic [63:0]              adv_lo_q;
	logic [31:0]              adv_hi_q;

	logic                     acc;
	logic [6:0]               pay;
	logic [63:0]              acc_new;
	logic [63:0]              off_cur;
	logic [3:0]               op;
	logic [3:0]               imm;
	logic [POSITION_BITS-1:0] cur_op_pos;
	logic                     reb;
	logic [63:0]              r_cnt;
	logic [63:0]              r_skip;
	logic [31:0]              remaining;
	logic                     fin;
	logic [2:0]               fin_st;
	logic [POSITION_BITS-1:0] fin_pos;
	logic                     run;
	phase_t                   ph_n;
	logic [3:0]               seg_n;
	logic                     segv_n;
	logic [3:0]               type_n;
	logic [63:0]              off_n;
	logic [63:0]              acc_n;
	logic [6:0]               shift_n;
	logic [63:0]              first_n;
	logic [63:0]              stride_w;
	logic [63:0]              prod_lo;
	logic [31:0]              prod_hi;

	assign in_ready = !cmd_full;
	assign acc = in_valid && in_ready;
	assign pay = stream_byte[6:0];
	assign op = (phase_q == PH_OPCODE) ? stream_byte[7:4] : op_q;
	assign imm = stream_byte[3:0];
	assign cur_op_pos = (phase_q == PH_OPCODE) ? pos_q : op_pos_q;
	assign off_cur = adv_pend_q ? offset_q + adv_lo_q + {adv_hi_q, 32'd0} : offset_q;
	assign acc_new = acc_q | ({57'd0, pay} << shift_q);
	assign remaining = (used_q > slot_limit) ? 32'd0 : slot_limit - used_q;
	assign stride_w = r_skip + SLOT_STEP;
	// count*stride mod 2^64 as two 32x32 products
	assign prod_lo = 64'(r_cnt[31:0]) * 64'(stride_w[31:0]);
	assign prod_hi = r_cnt[31:0] * stride_w[63:32];

	always_comb begin
		ph_n = phase_q;
		seg_n = seg_q;
		segv_n = seg_valid_q;
		type_n = type_q;
		off_n = off_cur;
		acc_n = acc_q;
		shift_n = shift_q;
		first_n = first_q;
		reb = 1'b0;
		r_cnt = 64'd0;
		r_skip = 64'd0;
		fin = 1'b0;
		fin_st = ST_OK;
		fin_pos = cur_op_pos;
		if (phase_q == PH_OPCODE) begin
			case (op)
				OP_DONE: begin
					fin = 1'b1;
				end
				OP_SET_TYPE: type_n = imm;
				OP_SET_SEG: begin
					if ({1'b0, imm} >= segment_count) begin
						fin = 1'b1;
						fin_st = ST_BAD_SEG;
					end else begin
						seg_n = imm;
						segv_n = 1'b1;
						ph_n = PH_ULEB1;
						acc_n = 64'd0;
						shift_n = 7'd0;
					end
				end
				OP_ADD_ULEB, OP_REB_ULEB, OP_REB_SKIP, OP_REB_ULEB_SKIP: begin
					ph_n = PH_ULEB1;
					acc_n = 64'd0;
					shift_n = 7'd0;
				end
				OP_ADD_IMM: off_n = off_cur + {57'd0, imm, 3'd0};
				OP_REB_IMM: begin
					reb = 1'b1;
					r_cnt = {60'd0, imm};
				end
				default: begin
					fin = 1'b1;
					fin_st = ST_UNKNOWN_OP;
				end
			endcase
		end else begin
			if (shift_q >= 7'd64 || (shift_q == 7'd63 && pay > 7'd1)) begin
				fin = 1'b1;
				fin_st = ST_BAD_ULEB;
			end else if (stream_byte[7]) begin
				acc_n = acc_new;
				shift_n = shift_q + 7'd7;
			end else begin
				ph_n = PH_OPCODE;
				acc_n = acc_new;
				case (op_q)
					OP_SET_SEG: off_n = acc_new;
					OP_ADD_ULEB: off_n = off_cur + acc_new;
					OP_REB_ULEB: begin
						reb = 1'b1;
						r_cnt = acc_new;
					end
					OP_REB_SKIP: begin
						reb = 1'b1;
						r_cnt = 64'd1;
						r_skip = acc_new;
					end
					OP_REB_ULEB_SKIP: begin
						if (phase_q == PH_ULEB1) begin
							first_n = acc_new;
							ph_n = PH_ULEB2;
							acc_n = 64'd0;
							shift_n = 7'd0;
						end else begin
							reb = 1'b1;
							r_cnt = first_q;
							r_skip = acc_new;
						end
					end
					default: ;
				endcase
			end
		end
		run = 1'b0;
		if (reb && !fin) begin
			if (!seg_valid_q) begin
				fin = 1'b1;
				fin_st = ST_NO_SEG;
			end else if (type_q != 4'd1 && type_q != 4'd2) begin
				fin = 1'b1;
				fin_st = ST_BAD_TYPE;
			end else if (r_cnt > {32'd0, remaining}) begin
				fin = 1'b1;
				fin_st = ST_SLOT_LIMIT;
			end else if (r_cnt != 64'd0) begin
				run = 1'b1;
			end
		end
		if (!fin && last_byte) begin
			fin = 1'b1;
			if (ph_n != PH_OPCODE) begin
				fin_st = ST_BAD_ULEB;
			end else begin
				fin_st = ST_OK;
				fin_pos = pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		cmd = '0;
		cmd.is_run = run;
		cmd.is_fin = fin;
		cmd.fin_after = run && fin;
		cmd.segment = seg_q;
		cmd.rtype = type_q;
		cmd.start = off_cur;
		cmd.count = r_cnt[31:0];
		cmd.stride = stride_w;
		cmd.status = fin_st;
		cmd.end_pos = 32'(fin_pos);
	end
	assign cmd_push = acc && !fin_q && (run || fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q <= OP_DONE;
			acc_q <= '0;
			shift_q <= '0;
			first_q <= '0;
			seg_q <= '0;
			seg_valid_q <= 1'b0;
			type_q <= '0;
			offset_q <= '0;
			used_q <= '0;
			pos_q <= '0;
			op_pos_q <= '0;
			fin_q <= 1'b0;
			adv_pend_q <= 1'b0;
			adv_lo_q <= '0;
			adv_hi_q <= '0;
		end else if (acc) begin
			if (last_byte) begin
				phase_q <= PH_OPCODE;
				op_q <= OP_DONE;
				acc_q <= '0;
				shift_q <= '0;
				first_q <= '0;
				seg_q <= '0;
				seg_valid_q <= 1'b0;
				type_q <= '0;
				offset_q <= '0;
				used_q <= '0;
				pos_q <= '0;
				op_pos_q <= '0;
				fin_q <= 1'b0;
				adv_pend_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (!fin_q) begin
					if (phase_q == PH_OPCODE) begin
						op_q <= stream_byte[7:4];
						op_pos_q <= pos_q;
					end
					fin_q <= fin;
					phase_q <= ph_n;
					acc_q <= acc_n;
					shift_q <= shift_n;
					first_q <= first_n;
					seg_q <= seg_n;
					seg_valid_q <= segv_n;
					type_q <= type_n;
					offset_q <= off_n;
					adv_pend_q <= run;
					adv_lo_q <= prod_lo;
					adv_hi_q <= prod_hi;
					if (run) used_q <= used_q + r_cnt[31:0];
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/rosd_back.sv */
// back end: command queue and record emitter with output register
`default_nettype none
module rosd_back
	import rosd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_push,
	input  cmd_t      cmd,
	output logic      cmd_full,
	output logic      out_valid,
	input  wire logic out_ready,
	output rec_t      rec
);
	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic                 run_done_q;  // run part of a two-record command sent
	logic                 pop;
	logic                 emit;
	logic                 load;
	cmd_t                 head;
	rec_t                 nrec;

	// keep one slot spare so ready does not depend on this cycle's pop
	assign cmd_full = cnt_q >= (QPTR_BITS+1)'(QUEUE_DEPTH - 1);
	assign head = mem_q[rd_q];
	assign load = !out_valid || out_ready;
	assign emit = (cnt_q != '0) && load;
	assign pop = emit && (!head.fin_after || run_done_q);

	always_comb begin
		nrec = '0;
		if (head.is_run && !run_done_q) begin
			nrec.record_kind = KIND_RUN;
			nrec.segment = head.segment;
			nrec.rebase_type = head.rtype;
			nrec.start_offset = head.start;
			nrec.run_count = head.count;
			nrec.stride = head.stride;
		end else begin
			nrec.record_kind = KIND_FINISH;
			nrec.status = head.status;
			nrec.end_position = head.end_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push) mem_q[wr_q] <= cmd;
		if (emit) rec <= nrec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			run_done_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd_push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(cmd_push) - (QPTR_BITS+1)'(pop);
			if (emit) run_done_q <= !pop;
			if (load) out_valid <= emit;
		end
	end
endmodule
`default_nettype wire

/* hdl/rebase_opcode_stream_decoder_top.sv */
// top level of the rebase opcode stream decoder
// channel   dir  carries
// bytes     in   stream_byte, last_byte
// records   out  one run or finish record per beat
// cfg       in   index 0 segment_count, 1 slot_limit
// one byte per cycle while the command queue has room; the front state and the
// offset advance multiply are registered, the product folded in on the next
// byte. a byte causing a run and a finish record is one command, sent by the
// back end as two records; the command queue absorbs this and output stalls.
// reset clears all control state, restores segment_count 16, slot_limit 1048576.
`default_nettype none
module rebase_opcode_stream_decoder_top
	import rosd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rosd_byte_if.sink in_ch,
	rosd_rec_if.source out_ch,
	rosd_cfg_if.sink  cfg
);
	logic [4:0]  seg_cnt_q;
	logic [31:0] slot_lim_q;
	logic        cmd_push;
	cmd_t        cmd;
	logic        cmd_full;
	rec_t        rec;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= 5'd16;
			slot_lim_q <= 32'd1048576;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SEGMENT_COUNT: seg_cnt_q <= cfg.data[4:0];
				CFG_SLOT_LIMIT: slot_lim_q <= cfg.data;
				default: ;
			endcase
		end
	end

	rosd_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.stream_byte(in_ch.stream_byte), .last_byte(in_ch.last_byte),
		.segment_count(seg_cnt_q), .slot_limit(slot_lim_q),
		.cmd_push, .cmd, .cmd_full
	);

	rosd_back u_back (
		.clk, .arst_n, .cmd_push, .cmd, .cmd_full,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .rec
	);

	assign out_ch.record_kind = rec.record_kind;
	assign out_ch.segment = rec.segment;
	assign out_ch.rebase_type = rec.rebase_type;
	assign out_ch.start_offset = rec.start_offset;
	assign out_ch.run_count = rec.run_count;
	assign out_ch.stride = rec.stride;
	assign out_ch.status = rec.status;
	assign out_ch.end_position = rec.end_position;
endmodule
`default_nettype wire
